// ----- src/lru_frame_replacement_unit_assert.svh -----
// Assertion macros for the LRU frame replacement block.
// Each macro expects clk and arst_n in scope.
`ifndef LRU_FRAME_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_FRAME_REPLACEMENT_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define LRUFR_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define LRUFR_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- src/lrufr_pkg.sv -----
`default_nettype none
package lrufr_pkg;

	localparam int FrameW           = 6;
	localparam int NumFramesDefault = 64;

	typedef enum logic {
		CMD_ACCESS = 1'b0,
		CMD_EVICT  = 1'b1
	} cmd_t;

	// What one cell hands to the next one toward the LRU end.
	typedef struct packed {
		logic [FrameW-1:0] frame;
		logic              valid;
		logic              hit_seen;
	} lrufr_link_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic              access;
		logic              evict;
		logic [FrameW-1:0] frame;
	} lrufr_ctrl_t;

endpackage
`default_nettype wire

// ----- src/lrufr_req_if.sv -----
`default_nettype none
interface lrufr_req_if import lrufr_pkg::*; ();
	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [FrameW-1:0] frame;

	modport source(output valid, cmd, frame, input ready);
	modport sink(input valid, cmd, frame, output ready);
endinterface
`default_nettype wire

// ----- src/lrufr_rsp_if.sv -----
`default_nettype none
interface lrufr_rsp_if import lrufr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FrameW-1:0] victim_frame;
	logic              empty_res;

	modport source(output valid, victim_frame, empty_res, input ready);
	modport sink(input valid, victim_frame, empty_res, output ready);
endinterface
`default_nettype wire

// ----- src/lrufr_cell.sv -----
`default_nettype none
module lrufr_cell import lrufr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lrufr_ctrl_t  ctrl,
	input  wire lrufr_link_t  up,
	input  wire logic         down_valid,
	output lrufr_link_t       link,
	output logic              tail,
	output logic [FrameW-1:0] tail_frame
);

	logic [FrameW-1:0] frame_q;
	logic              valid_q;
	logic              hit_here;

	assign hit_here   = valid_q && (frame_q == ctrl.frame);
	assign link       = '{frame: frame_q, valid: valid_q, hit_seen: up.hit_seen | hit_here};
	assign tail       = valid_q && !down_valid;
	assign tail_frame = tail ? frame_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			valid_q <= 1'b0;
		end else if (ctrl.access) begin
			// shift toward the LRU end until the slot that held the frame
			if (!up.hit_seen) begin
				frame_q <= up.frame;
				valid_q <= up.valid;
			end
		end else if (ctrl.evict && tail) begin
			frame_q <= '0;
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- src/lru_frame_replacement_unit.sv -----
// LRU frame replacement unit.
// req channel (valid/ready): cmd = CMD_ACCESS moves frame to the most recent
// position, or inserts it there when untracked; frames at or above NUM_FRAMES
// are dropped. cmd = CMD_EVICT removes the least recently used frame.
// rsp channel (valid/ready): one transfer per evict only, carrying
// victim_frame and empty_res (set, with victim_frame 0, when nothing is
// tracked). Access commands produce no transfer.
// A row of NUM_FRAMES cells holds the recency order, slot 0 most recent;
// each cell compares its frame and takes its neighbor's entry on a shift.
// Throughput: one command per cycle while rsp does not stall. An evict result
// shows on rsp in the cycle after its request transfer, from a single output register.
// When rsp stalls, the output register holds and req.ready drops until the
// result is taken; accesses are then held back as well.
// Reset: asynchronous, clears every cell, so no frame is tracked and the
// output register is empty; there is no clearing pass.
`default_nettype none
`include "lru_frame_replacement_unit_assert.svh"
module lru_frame_replacement_unit import lrufr_pkg::*; #(
	parameter int NUM_FRAMES = NumFramesDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lrufr_req_if.sink   req,
	lrufr_rsp_if.source rsp
);

	lrufr_ctrl_t       ctrl;
	lrufr_link_t       link      [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] valid_vec;
	logic [NUM_FRAMES-1:0] tail_vec;
	logic [FrameW-1:0] victim_or [NUM_FRAMES+1];
	logic              req_xfer;
	logic              frame_ok;
	logic              out_valid_q;
	logic [FrameW-1:0] victim_q;
	logic              empty_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign req_xfer  = req.valid && req.ready;
	assign frame_ok  = int'(req.frame) < NUM_FRAMES;

	assign ctrl.access = req_xfer && (req.cmd == CMD_ACCESS) && frame_ok;
	assign ctrl.evict  = req_xfer && (req.cmd == CMD_EVICT);
	assign ctrl.frame  = req.frame;

	assign victim_or[0] = '0;

	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		lrufr_link_t       up;
		logic              down_valid;
		logic [FrameW-1:0] tail_frame;

		if (i == 0) begin : g_head
			assign up = '{frame: req.frame, valid: 1'b1, hit_seen: 1'b0};
		end else begin : g_body
			assign up = link[i-1];
		end

		if (i == NUM_FRAMES - 1) begin : g_last
			assign down_valid = 1'b0;
		end else begin : g_mid
			assign down_valid = link[i+1].valid;
		end

		lrufr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.up         (up),
			.down_valid (down_valid),
			.link       (link[i]),
			.tail       (tail_vec[i]),
			.tail_frame (tail_frame)
		);

		assign valid_vec[i]   = link[i].valid;
		assign victim_or[i+1] = victim_or[i] | tail_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.evict) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.evict) begin
			victim_q <= victim_or[NUM_FRAMES];
			empty_q  <= !valid_vec[0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.victim_frame = victim_q;
	assign rsp.empty_res    = empty_q;

	`LRUFR_ASSERT_NOW(a_valid_run, 1'b1, $onehot({1'b0, valid_vec} + 1'b1),
		"valid slots not a run from slot 0")
	`LRUFR_ASSERT_NOW(a_one_tail, 1'b1, $onehot0(tail_vec), "more than one LRU tail")
	`LRUFR_ASSERT_NEXT(a_empty_evict, ctrl.evict && !valid_vec[0],
		rsp.valid && rsp.empty_res, "empty evict not flagged")
	`LRUFR_ASSERT_NEXT(a_access_mru, ctrl.access,
		valid_vec[0] && link[0].frame == $past(req.frame), "access not at MRU slot")

endmodule
`default_nettype wire

// ----- tb/tb_lru_frame_replacement_unit.sv -----
`default_nettype none
module tb_lru_frame_replacement_unit;
	import lrufr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN    = 200;

	typedef struct packed {
		logic [FrameW-1:0] frame;
		logic              empty;
	} victim_t;

	// Keeps its own recency order and the victims that evicts must return.
	class lru_order_scoreboard;
		int                num_frames;
		logic [FrameW-1:0] recency[$];
		victim_t           victims_due[$];
		int                errors;
		int                accesses;
		int                rehits;
		int                evicts;
		int                empty_evicts;
		int                peak_depth;

		function new(int frames);
			num_frames = frames;
		endfunction

		function int pending();
			return victims_due.size();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function void note_request(cmd_t c, logic [FrameW-1:0] f);
			int      hit_pos;
			victim_t v;
			hit_pos = -1;
			if (c == CMD_ACCESS) begin
				if (f < num_frames) begin
					accesses++;
					foreach (recency[i])
						if (hit_pos < 0 && recency[i] == f)
							hit_pos = i;
					if (hit_pos >= 0) begin
						recency.delete(hit_pos);
						rehits++;
					end else if (recency.size() == num_frames) begin
						// drop the LRU entry to make room
						recency.delete(recency.size() - 1);
					end
					recency.insert(0, f);
					if (recency.size() > peak_depth)
						peak_depth = recency.size();
				end
			end else begin
				evicts++;
				if (recency.size() == 0) begin
					v.frame = '0;
					v.empty = 1'b1;
					empty_evicts++;
				end else begin
					v.frame = recency[$];
					v.empty = 1'b0;
					recency.delete(recency.size() - 1);
				end
				victims_due.push_back(v);
			end
		endfunction

		task check_victim(logic [FrameW-1:0] frame, logic empty);
			victim_t want;
			if (victims_due.size() == 0) begin
				report_mismatch($sformatf("unexpected victim transfer: frame %0d empty %0b",
					frame, empty));
				return;
			end
			want = victims_due.pop_front();
			if (frame !== want.frame)
				report_mismatch($sformatf("victim_frame %0d, want %0d", frame, want.frame));
			if (empty !== want.empty)
				report_mismatch($sformatf("empty_res %0b, want %0b", empty, want.empty));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_pending;
	int   hold_left;
	int   cycles;
	int   order[64];
	int   tmp;
	int   j;

	lru_order_scoreboard sb;

	lrufr_req_if req ();
	lrufr_rsp_if rsp ();

	lru_frame_replacement_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Check the result first: it belongs to an evict taken at an earlier edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_victim(rsp.victim_frame, rsp.empty_res);
			if (req.valid && req.ready)
				sb.note_request(req.cmd, req.frame);
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d victims still due", cycles, sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

	task automatic issue_cmd(cmd_t c, logic [FrameW-1:0] f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= c;
		req.frame <= f;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_random(int count, int evict_pct);
		int span;
		span = ($urandom_range(0, 2) == 0) ? 8 : (($urandom_range(0, 1) == 0) ? 24 : 64);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < evict_pct)
				issue_cmd(CMD_EVICT, FrameW'($urandom_range(0, 63)));
			else
				issue_cmd(CMD_ACCESS, FrameW'($urandom_range(0, span - 1)));
		end
	endtask

	// Hold the request side idle until every victim has been returned.
	task automatic wait_for_victims();
		req.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		sb             = new(NumFramesDefault);
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.cmd        = CMD_ACCESS;
		req.frame      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_pending   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// evict on an empty order, frame field ignored
		issue_cmd(CMD_EVICT, 6'd0);
		issue_cmd(CMD_EVICT, 6'd63);
		issue_cmd(CMD_ACCESS, 6'd0);
		issue_cmd(CMD_ACCESS, 6'd63);
		// re-access from the LRU end, the middle and the MRU slot
		issue_cmd(CMD_ACCESS, 6'd0);
		issue_cmd(CMD_ACCESS, 6'd21);
		issue_cmd(CMD_ACCESS, 6'd42);
		issue_cmd(CMD_ACCESS, 6'd63);
		issue_cmd(CMD_ACCESS, 6'd63);
		issue_cmd(CMD_ACCESS, 6'd21);
		issue_cmd(CMD_EVICT, 6'd42);
		issue_cmd(CMD_EVICT, 6'd0);
		issue_cmd(CMD_EVICT, 6'd0);
		issue_cmd(CMD_EVICT, 6'd0);
		issue_cmd(CMD_EVICT, 6'd0);
		issue_cmd(CMD_ACCESS, 6'd5);
		issue_cmd(CMD_EVICT, 6'd5);
		issue_cmd(CMD_ACCESS, 6'd42);
		issue_cmd(CMD_ACCESS, 6'd21);
		wait_for_victims();

		// fill every frame in random order, hit the full order, then drain it
		for (int i = 0; i < 64; i++)
			order[i] = i;
		for (int i = 63; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 64; i++)
			issue_cmd(CMD_ACCESS, FrameW'(order[i]));
		for (int i = 0; i < 24; i++)
			issue_cmd(CMD_ACCESS, FrameW'($urandom_range(0, 63)));
		for (int i = 0; i < 66; i++)
			issue_cmd(CMD_EVICT, FrameW'($urandom_range(0, 63)));
		wait_for_victims();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			if (phase == 2) begin
				// stall the receiver while evicts keep coming, so input backs up
				hold_pending = 1'b1;
				send_random(40, 60);
			end
			send_random(40, 15);
			send_random(35, 45);
			send_random(25, 75);
			wait_for_victims();
		end

		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d victims never returned", sb.pending()));
		$display("Covered %0d accesses (%0d to frames already tracked), peak depth %0d of %0d",
			sb.accesses, sb.rehits, sb.peak_depth, NumFramesDefault);
		$display("and %0d evicts (%0d on an empty order) under four idle/stall mixes",
			sb.evicts, sb.empty_evicts);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
